/* rtl/gcd_pkg.sv */
// Shared types and constants for the great-circle distance pipeline.
// Used by the CORDIC and square-root cells and by the top level.
package gcd_pkg;

   localparam int MaxStages = 32;

   // The low 32 bits of the microdegree-to-binary-angle scale; the high part is 5.
   localparam logic [31:0] ANG_LO = 32'd4145641400;
   localparam logic [31:0] GAIN_Q30 = 32'd652032874;
   // The low 32 bits of the metres scale; the high part is 2.
   localparam logic [31:0] DIST_LO = 32'd1669269680;
   localparam logic [24:0] DIST_MAX = 25'd20037509;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } gcd_vec_type;

   typedef struct packed {
      logic [32:0] rem;
      logic [30:0] root;
      logic [61:0] rad;
   } gcd_root_type;

   function automatic logic signed [33:0] atan_entry(input int idx);
      logic signed [33:0] r;
      case (idx)
         0: r = 34'sh20000000;
         1: r = 34'sh12E4051E;
         2: r = 34'sh09FB385B;
         3: r = 34'sh051111D4;
         4: r = 34'sh028B0D43;
         5: r = 34'sh0145D7E1;
         6: r = 34'sh00A2F61E;
         7: r = 34'sh00517C55;
         8: r = 34'sh0028BE53;
         9: r = 34'sh00145F2E;
         10: r = 34'sh000A2F98;
         11: r = 34'sh000517CC;
         12: r = 34'sh00028BE6;
         13: r = 34'sh000145F3;
         14: r = 34'sh0000A2F9;
         15: r = 34'sh0000517C;
         16: r = 34'sh000028BE;
         17: r = 34'sh0000145F;
         18: r = 34'sh00000A2F;
         19: r = 34'sh00000517;
         20: r = 34'sh0000028B;
         21: r = 34'sh00000145;
         22: r = 34'sh000000A2;
         23: r = 34'sh00000051;
         24: r = 34'sh00000028;
         25: r = 34'sh00000014;
         26: r = 34'sh0000000A;
         27: r = 34'sh00000005;
         28: r = 34'sh00000002;
         29: r = 34'sh00000001;
         default: r = 34'sh0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/gcd_cordic_cell.sv */
// One CORDIC micro-rotation, rotation or vectoring mode, registered.
// Depends on gcd_pkg for the lane type and the arctangent constants.
module gcd_cordic_cell #(
   parameter int STAGE  = 0,
   parameter bit VECTOR = 1'b0
) (
   input  logic                 clock,
   input  logic                 en,
   input  gcd_pkg::gcd_vec_type vin,
   output gcd_pkg::gcd_vec_type vout
);

   localparam logic signed [33:0] Atan = gcd_pkg::atan_entry(STAGE);

   gcd_pkg::gcd_vec_type vec_ff, vec_in;
   logic signed [33:0] dx, dy;
   logic               dpos;

   always_comb begin
      dx = vin.y >>> STAGE;
      dy = vin.x >>> STAGE;
      dpos = VECTOR ? !(vin.y > 34'sd0) : (vin.z >= 34'sd0);
      if (dpos) begin
         vec_in.x = vin.x - dx;
         vec_in.y = vin.y + dy;
         vec_in.z = vin.z - Atan;
      end else begin
         vec_in.x = vin.x + dx;
         vec_in.y = vin.y - dy;
         vec_in.z = vin.z + Atan;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign vout = vec_ff;

endmodule

/* rtl/gcd_sqrt_cell.sv */
// One digit of a restoring integer square root, registered.
// Depends on gcd_pkg for the root lane type.
module gcd_sqrt_cell (
   input  logic                  clock,
   input  logic                  en,
   input  gcd_pkg::gcd_root_type vin,
   output gcd_pkg::gcd_root_type vout
);

   gcd_pkg::gcd_root_type rt_ff, rt_in;
   logic [34:0] r2;
   logic [34:0] trial;

   always_comb begin
      r2 = {vin.rem, vin.rad[61:60]};
      trial = {2'b00, vin.root, 2'b01};
      rt_in.rad = {vin.rad[59:0], 2'b00};
      if (r2 >= trial) begin
         rt_in.rem = 33'(r2 - trial);
         rt_in.root = {vin.root[29:0], 1'b1};
      end else begin
         rt_in.rem = r2[32:0];
         rt_in.root = {vin.root[29:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rt_ff <= rt_in;
      end
   end

   assign vout = rt_ff;

endmodule

/* rtl/great_circle_distance.sv */
// Haversine great-circle distance on a 6378.137 km sphere, fully pipelined.
// Depends on gcd_pkg, gcd_cordic_cell and gcd_sqrt_cell.
//
// Takes one pair of points per cycle unless the result side stalls, and returns
// the distance in whole metres, rounded and capped at half the circumference.
// It has two chains of CORDIC_STAGES cells, at most MaxStages (sine/cosine of
// four angles, then arctangent), two 31-cell square-root chains, arithmetic stages.
// A stall on the result side freezes the whole pipeline and stalls the input.
module great_circle_distance #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [27:0] req_lat_a,
   input  logic [28:0] req_lng_a,
   input  logic [27:0] req_lat_b,
   input  logic [28:0] req_lng_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [24:0] rsp_distance_m
);

   localparam int N   = (CORDIC_STAGES > gcd_pkg::MaxStages) ? gcd_pkg::MaxStages
                                                             : CORDIC_STAGES;
   localparam int LAT = 2 * N + 43;

   logic en;
   logic [LAT-1:0] vld_ff;

   // Stage 1: magnitudes and signs
   logic signed [29:0] src [4];
   logic [29:0] mag_ff [4];
   logic [3:0]  neg_ff;
   // Stage 2: partial products
   logic [61:0] plo_ff [4];
   logic [32:0] m5_ff [4];
   logic [3:0]  neg2_ff;
   // Stage 3: binary angles
   logic [31:0] ang_ff [4];
   // Stage 4: quadrant and CORDIC seed
   gcd_pkg::gcd_vec_type rot [N+1][4];
   gcd_pkg::gcd_vec_type seed_ff [4];
   logic [1:0] q_ff [N+1][4];
   // Trig results
   logic signed [33:0] s1_ff, s2_ff, ca_ff, cb_ff;
   logic signed [67:0] p1_ff, p2_ff, pc_ff;
   logic signed [33:0] sq1_ff, sq2_ff, cc_ff;
   logic signed [33:0] sq1d_ff;
   logic signed [67:0] ph_ff;
   logic signed [35:0] hraw_ff;
   gcd_pkg::gcd_root_type rx [32];
   gcd_pkg::gcd_root_type ry [32];
   gcd_pkg::gcd_root_type radx_ff, rady_ff;
   gcd_pkg::gcd_vec_type vec [N+1];
   logic [61:0] zp_ff;
   logic [30:0] zc_ff;
   logic [24:0] dist_ff;

   function automatic logic [29:0] abs_mag(input logic signed [29:0] v);
      return v[29] ? 30'(-v) : 30'(v);
   endfunction

   assign rsp_valid = vld_ff[LAT-1];
   assign en = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign rsp_distance_m = dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   always_comb begin
      src[0] = 30'(signed'({{2{req_lat_a[27]}}, req_lat_a}))
             - 30'(signed'({{2{req_lat_b[27]}}, req_lat_b}));
      src[1] = 30'(signed'({req_lng_a[28], req_lng_a}))
             - 30'(signed'({req_lng_b[28], req_lng_b}));
      src[2] = signed'({{2{req_lat_a[27]}}, req_lat_a});
      src[3] = signed'({{2{req_lat_b[27]}}, req_lat_b});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 4; l++) begin
            mag_ff[l] <= abs_mag(src[l]);
            neg_ff[l] <= src[l][29];
            plo_ff[l] <= 62'(mag_ff[l]) * 62'(gcd_pkg::ANG_LO);
            m5_ff[l] <= {3'b000, mag_ff[l]} + {1'b0, mag_ff[l], 2'b00};
         end
         neg2_ff <= neg_ff;
      end
   end

   logic [64:0] asum [4];
   logic [31:0] araw [4];
   logic [31:0] adj [4];
   logic [1:0]  qd [4];

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         asum[l] = {3'b000, plo_ff[l]} + {m5_ff[l], 32'h0}
                 + ((l < 2) ? 65'h8000_0000 : 65'h4000_0000);
         araw[l] = (l < 2) ? asum[l][63:32] : asum[l][62:31];
         qd[l] = 2'((ang_ff[l] + 32'h2000_0000) >> 30);
         adj[l] = ang_ff[l] - {qd[l], 30'h0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 4; l++) begin
            ang_ff[l] <= neg2_ff[l] ? 32'(-araw[l]) : araw[l];
            seed_ff[l].x <= signed'({2'b00, gcd_pkg::GAIN_Q30});
            seed_ff[l].y <= '0;
            seed_ff[l].z <= signed'({{2{adj[l][31]}}, adj[l]});
            q_ff[0][l] <= qd[l];
         end
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_lane
      assign rot[0][l] = seed_ff[l];
      for (genvar i = 0; i < N; i++) begin : g_rot
         gcd_cordic_cell #(.STAGE(i), .VECTOR(1'b0)) u_cell (
            .clock (clock),
            .en    (en),
            .vin   (rot[i][l]),
            .vout  (rot[i+1][l])
         );
         always_ff @(posedge clock) begin
            if (en) begin
               q_ff[i+1][l] <= q_ff[i][l];
            end
         end
      end
   end

   function automatic logic signed [33:0] sin_of(input gcd_pkg::gcd_vec_type v,
                                                  input logic [1:0] q);
      logic signed [33:0] r;
      case (q)
         2'd0: r = v.y;
         2'd1: r = v.x;
         2'd2: r = -v.y;
         default: r = -v.x;
      endcase
      return r;
   endfunction

   function automatic logic signed [33:0] cos_of(input gcd_pkg::gcd_vec_type v,
                                                  input logic [1:0] q);
      logic signed [33:0] r;
      case (q)
         2'd0: r = v.x;
         2'd1: r = -v.y;
         2'd2: r = -v.x;
         default: r = v.y;
      endcase
      return r;
   endfunction

   logic signed [35:0] hsum;
   logic [30:0] hcl;
   logic signed [67:0] sq2w;

   always_comb begin
      sq2w = 68'(sq2_ff);
      hsum = 36'(sq1d_ff) + 36'(ph_ff >>> 30);
      if (hraw_ff < 36'sd0) begin
         hcl = '0;
      end else if (hraw_ff > signed'({5'b0, gcd_pkg::ONE_Q30})) begin
         hcl = gcd_pkg::ONE_Q30;
      end else begin
         hcl = hraw_ff[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= sin_of(rot[N][0], q_ff[N][0]);
         s2_ff <= sin_of(rot[N][1], q_ff[N][1]);
         ca_ff <= cos_of(rot[N][2], q_ff[N][2]);
         cb_ff <= cos_of(rot[N][3], q_ff[N][3]);
         p1_ff <= 68'(s1_ff) * 68'(s1_ff);
         p2_ff <= 68'(s2_ff) * 68'(s2_ff);
         pc_ff <= 68'(ca_ff) * 68'(cb_ff);
         sq1_ff <= 34'(p1_ff >>> 30);
         sq2_ff <= 34'(p2_ff >>> 30);
         cc_ff <= 34'(pc_ff >>> 30);
         ph_ff <= 68'(cc_ff) * sq2w;
         sq1d_ff <= sq1_ff;
         hraw_ff <= hsum;
         radx_ff.rem <= '0;
         radx_ff.root <= '0;
         radx_ff.rad <= {1'b0, 31'(gcd_pkg::ONE_Q30 - hcl), 30'h0};
         rady_ff.rem <= '0;
         rady_ff.root <= '0;
         rady_ff.rad <= {1'b0, hcl, 30'h0};
      end
   end

   assign rx[0] = radx_ff;
   assign ry[0] = rady_ff;

   for (genvar i = 0; i < 31; i++) begin : g_sqrt
      gcd_sqrt_cell u_sx (
         .clock (clock),
         .en    (en),
         .vin   (rx[i]),
         .vout  (rx[i+1])
      );
      gcd_sqrt_cell u_sy (
         .clock (clock),
         .en    (en),
         .vin   (ry[i]),
         .vout  (ry[i+1])
      );
   end

   assign vec[0].x = signed'({3'b000, rx[31].root});
   assign vec[0].y = signed'({3'b000, ry[31].root});
   assign vec[0].z = '0;

   for (genvar i = 0; i < N; i++) begin : g_vec
      gcd_cordic_cell #(.STAGE(i), .VECTOR(1'b1)) u_cell (
         .clock (clock),
         .en    (en),
         .vin   (vec[i]),
         .vout  (vec[i+1])
      );
   end

   logic [30:0] zcl;
   logic [64:0] dsum;
   logic [25:0] draw;

   always_comb begin
      if (vec[N].z < 34'sd0) begin
         zcl = '0;
      end else if (vec[N].z > signed'({3'b000, gcd_pkg::ONE_Q30})) begin
         zcl = gcd_pkg::ONE_Q30;
      end else begin
         zcl = vec[N].z[30:0];
      end
      dsum = {3'b000, zp_ff} + {1'b0, zc_ff, 33'h0} + 65'h40_0000_0000;
      draw = dsum[64:39];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zp_ff <= 62'(zcl) * 62'(gcd_pkg::DIST_LO);
         zc_ff <= zcl;
         dist_ff <= (draw > 26'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : draw[24:0];
      end
   end

endmodule
